[rtl/fsync_pkg.sv]
// shared constants, types and helpers of the frame synchroniser
`timescale 1ns / 1ps
`default_nettype none
package fsync_pkg;

  localparam int MAX_FRAME  = 64;
  localparam int WIN_AW     = $clog2(MAX_FRAME);
  localparam int LEN_W      = WIN_AW + 1;
  localparam int BYTE_W     = 8;
  localparam int HELD_W     = 8;
  localparam int FIFO_DEPTH = MAX_FRAME;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int ROOM_W     = FIFO_AW + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DW     = 8;

  localparam logic [HELD_W-1:0] FLUSH_LIMIT   = HELD_W'(128);
  localparam logic [LEN_W-1:0]  FRAME_LEN_RST = LEN_W'(8);
  localparam logic [LEN_W-1:0]  FRAME_LEN_MIN = LEN_W'(2);
  localparam logic [LEN_W-1:0]  FRAME_LEN_MAX = LEN_W'(MAX_FRAME);

  localparam logic [CFG_IDX_W-1:0] REG_PACKET_ID    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = CFG_IDX_W'(1);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } fs_word_t;

  // clamp the programmed length into the supported range
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] fl);
    logic [LEN_W-1:0] len;
    len = fl;
    if (len < FRAME_LEN_MIN) len = FRAME_LEN_MIN;
    if (len > FRAME_LEN_MAX) len = FRAME_LEN_MAX;
    return len;
  endfunction

endpackage
`default_nettype wire

[rtl/fsync_fifo.sv]
// result word queue with registered head
`timescale 1ns / 1ps
`default_nettype none
module fsync_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_push,
  input  wire fsync_pkg::fs_word_t q_word,
  output logic [fsync_pkg::ROOM_W-1:0] q_room,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output fsync_pkg::fs_word_t     out_word
);
  import fsync_pkg::*;

  fs_word_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wptr_r;
  logic [FIFO_AW-1:0]     rptr_r;
  logic [ROOM_W-1:0]      cnt_r;
  logic [ROOM_W-1:0]      cnt_nxt;
  fs_word_t               head_r;
  logic                   head_vld_r;
  logic                   load;

  // head register refills from memory once the previous word has left
  assign load      = (cnt_r != '0) && (!head_vld_r || out_pop);
  assign out_empty = !head_vld_r;
  assign out_word  = head_r;
  assign q_room    = ROOM_W'(FIFO_DEPTH) - cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) cnt_nxt = cnt_nxt + ROOM_W'(1);
    if (load)   cnt_nxt = cnt_nxt - ROOM_W'(1);
  end

  always_ff @(posedge clk) begin
    if (q_push) mem[wptr_r] <= q_word;
    if (load)   head_r <= mem[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r     <= '0;
      rptr_r     <= '0;
      cnt_r      <= '0;
      head_vld_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_push) wptr_r <= wptr_r + FIFO_AW'(1);
      if (load) begin
        rptr_r     <= rptr_r + FIFO_AW'(1);
        head_vld_r <= 1'b1;
      end else if (out_pop) begin
        head_vld_r <= 1'b0;
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (cnt_r != ROOM_W'(FIFO_DEPTH)))
    else $error("fsync_fifo: push into full queue");

  a_head_fill : assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && !head_vld_r |=> head_vld_r)
    else $error("fsync_fifo: head not refilled");

endmodule
`default_nettype wire

[rtl/fsync_front.sv]
// byte window, xor check and frame readout
`timescale 1ns / 1ps
`default_nettype none
module fsync_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [fsync_pkg::BYTE_W-1:0]    in_rx_byte,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fsync_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fsync_pkg::CFG_DW-1:0]    cfg_data,
  input  wire logic [fsync_pkg::ROOM_W-1:0]    q_room,
  output logic                                 q_push,
  output fsync_pkg::fs_word_t                  q_word
);
  import fsync_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_WAIT, ST_READ} state_t;

  // each entry: received byte and running xor of everything before it
  logic [2*BYTE_W-1:0]  win_mem [MAX_FRAME];
  logic [2*BYTE_W-1:0]  rdata_r;

  state_t               state_r;
  logic [BYTE_W-1:0]    packet_id_r;
  logic [LEN_W-1:0]     frame_len_r;
  logic [WIN_AW-1:0]    wptr_r;
  logic [BYTE_W-1:0]    pref_r;
  logic [HELD_W-1:0]    held_r;
  logic [WIN_AW-1:0]    rptr_r;
  logic [LEN_W-1:0]     remain_r;
  logic                 push_r;
  logic                 last_r;

  logic [LEN_W-1:0]     len;
  logic                 accept;
  logic [WIN_AW-1:0]    raddr;
  logic                 is_frame;

  assign len       = eff_len(frame_len_r);
  assign in_full   = (state_r != ST_IDLE);
  assign accept    = in_push && (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // while idle, fetch the oldest byte of the window ending at the new byte
  assign raddr = (state_r == ST_READ) ? rptr_r
               : wptr_r - len[WIN_AW-1:0] + WIN_AW'(1);

  // whole-window xor is zero exactly when the checksum byte matches
  assign is_frame = (held_r >= HELD_W'(len))
                 && (rdata_r[2*BYTE_W-1:BYTE_W] == packet_id_r)
                 && ((pref_r ^ rdata_r[BYTE_W-1:0]) == '0);

  assign q_push      = push_r;
  assign q_word.data = rdata_r[2*BYTE_W-1:BYTE_W];
  assign q_word.last = last_r;

  always_ff @(posedge clk) begin
    if (accept) win_mem[wptr_r] <= {in_rx_byte, pref_r};
    rdata_r <= win_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      packet_id_r <= '0;
      frame_len_r <= FRAME_LEN_RST;
      wptr_r      <= '0;
      pref_r      <= '0;
      held_r      <= '0;
      push_r      <= 1'b0;
    end else begin
      push_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_PACKET_ID:    packet_id_r <= cfg_data;
          REG_FRAME_LENGTH: frame_len_r <= cfg_data[LEN_W-1:0];
          default:          ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_push) begin
            wptr_r  <= wptr_r + WIN_AW'(1);
            pref_r  <= pref_r ^ in_rx_byte;
            if (held_r != '1) held_r <= held_r + HELD_W'(1);
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (is_frame) begin
            held_r   <= '0;
            rptr_r   <= wptr_r - len[WIN_AW-1:0];
            remain_r <= len;
            state_r  <= ST_WAIT;
          end else begin
            if (held_r > FLUSH_LIMIT) held_r <= '0;
            state_r <= ST_IDLE;
          end
        end
        ST_WAIT: begin
          // whole frame must fit in the queue before readout starts
          if (q_room >= len) state_r <= ST_READ;
        end
        ST_READ: begin
          rptr_r   <= rptr_r + WIN_AW'(1);
          remain_r <= remain_r - LEN_W'(1);
          push_r   <= 1'b1;
          last_r   <= (remain_r == LEN_W'(1));
          if (remain_r == LEN_W'(1)) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_check_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> $past(accept))
    else $error("fsync_front: check without a received byte");

  a_read_count_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (held_r == '0))
    else $error("fsync_front: held count not cleared during readout");

  a_last_ends_read : assert property (@(posedge clk) disable iff (!rst_n)
    (push_r && last_r) |-> (state_r == ST_IDLE))
    else $error("fsync_front: readout continues past frame end");

endmodule
`default_nettype wire

[rtl/xor_checked_frame_sync.sv]
// Each received byte occupies the input while it is stored, then window-checked.
// On a match, readout starts once the result queue has room for the frame and
// then moves one frame byte per cycle; input is held until the last frame byte
// has been read out of the window.
// Synchronous active-low reset clears control state and loads register defaults;
// the window memory is not cleared, so no reset sweep is needed.
`timescale 1ns / 1ps
`default_nettype none
module xor_checked_frame_sync (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [fsync_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [fsync_pkg::BYTE_W-1:0]         out_frame_byte,
  output logic                                 out_frame_end,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fsync_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fsync_pkg::CFG_DW-1:0]    cfg_data
);
  import fsync_pkg::*;

  logic              q_push;
  fs_word_t          q_word;
  logic [ROOM_W-1:0] q_room;
  fs_word_t          out_word;

  fsync_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_rx_byte (in_rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_room     (q_room),
    .q_push     (q_push),
    .q_word     (q_word)
  );

  fsync_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_push    (q_push),
    .q_word    (q_word),
    .q_room    (q_room),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

  assign out_frame_byte = out_word.data;
  assign out_frame_end  = out_word.last;

endmodule
`default_nettype wire

[dv/tb_top.sv]
// testbench for the xor-checked frame synchroniser: directed table, then random frames
`timescale 1ns / 1ps
module tb_top;
  import fsync_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE       = 16;
  localparam int REPORT_MAX   = 10;
  localparam int PLAN_ROWS    = 30;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [7:0]             val;
    bit                     pinned;
    int                     pin_n;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [BYTE_W-1:0]     in_rx_byte = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [BYTE_W-1:0]     out_frame_byte;
  logic                  out_frame_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DW-1:0]     cfg_data = '0;

  // predictor state
  logic [7:0] hist [MAX_FRAME];
  logic [7:0] held = '0;
  logic [7:0] pid_q = '0;
  logic [6:0] flen_q = 7'd8;

  fs_word_t   due_words [$];
  plan_row_t  plan [PLAN_ROWS];
  int         idle_pct = 13;
  int         err_cnt = 0;
  int         cycles = 0;
  int         bytes_sent = 0;
  int         frames_seen = 0;
  int         flushes = 0;

  xor_checked_frame_sync i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_rx_byte     (in_rx_byte),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still due", cycles, due_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic flag_error(input string what);
    err_cnt++;
    if (err_cnt <= REPORT_MAX) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  function automatic int cur_len();
    int len;
    len = flen_q;
    if (len < 2) len = 2;
    if (len > MAX_FRAME) len = MAX_FRAME;
    return len;
  endfunction

  // shift one byte into the window and work out any frame it closes
  task automatic take_byte(input logic [7:0] b, input bit queue_it);
    int len;
    int k;
    logic [7:0] acc;
    fs_word_t w;
    len = cur_len();
    for (k = MAX_FRAME - 1; k > 0; k--) hist[k] = hist[k-1];
    hist[0] = b;
    if (held != 8'hFF) held++;
    if (held < len) return;
    if (hist[len-1] == pid_q) begin
      acc = '0;
      for (k = 1; k < len; k++) acc ^= hist[k];
      if (acc == hist[0]) begin
        if (queue_it) begin
          for (k = 0; k < len; k++) begin
            w.data = hist[len-1-k];
            w.last = (k == len - 1);
            due_words = {due_words, w};
          end
        end
        held = '0;
        return;
      end
    end
    if (held > FLUSH_LIMIT) begin
      held = '0;
      flushes++;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input bit queue_it);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
    take_byte(b, queue_it);
    bytes_sent++;
  endtask

  // hold the sender until every due word is out, then let the block settle
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_PACKET_ID) pid_q = val;
    else if (idx == REG_FRAME_LENGTH) flen_q = val[6:0];
  endtask

  task automatic send_frame(input bit spoil);
    logic [7:0] body [MAX_FRAME];
    logic [7:0] acc;
    int len;
    int k;
    int hit;
    len = cur_len();
    body[0] = pid_q;
    acc = pid_q;
    for (k = 1; k < len - 1; k++) begin
      body[k] = 8'($urandom_range(255));
      acc ^= body[k];
    end
    body[len-1] = acc;
    if (spoil) begin
      hit = int'($urandom_range(len - 1));
      body[hit] ^= 8'h01 << $urandom_range(7);
    end
    for (k = 0; k < len; k++) push_byte(body[k], 1'b1);
  endtask

  // mostly clean frames, some with one bit flipped, some line noise
  task automatic send_mix(input int units);
    int r;
    repeat (units) begin
      r = $urandom_range(99);
      if (r < 70) send_frame(1'b0);
      else if (r < 85) send_frame(1'b1);
      else repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)), 1'b1);
    end
  endtask

  always @(posedge clk) begin : pop_side
    fs_word_t w;
    if (rst_n && out_pop && !out_empty) begin
      if (due_words.size() == 0) begin
        flag_error($sformatf("word %02h end %0b with nothing due", out_frame_byte,
                             out_frame_end));
      end else begin
        w = due_words.pop_front();
        if (out_frame_byte !== w.data || out_frame_end !== w.last)
          flag_error($sformatf("expected byte %02h end %0b, got byte %02h end %0b",
                               w.data, w.last, out_frame_byte, out_frame_end));
      end
      if (out_frame_end === 1'b1) frames_seen++;
    end
    out_pop <= ($urandom_range(99) >= idle_pct);
  end

  initial begin : main
    fs_word_t w;
    int r;
    int k;
    logic [7:0] b;
    for (k = 0; k < MAX_FRAME; k++) hist[k] = '0;
    plan = '{
      // reset values: id 0, length 8, so eight zero bytes make a frame
      '{ROW_BYTE, REG_PACKET_ID,    8'h00, 1'b1, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h00, 1'b1, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h00, 1'b1, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h00, 1'b1, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h00, 1'b1, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h00, 1'b1, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h00, 1'b1, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h00, 1'b1, 8},
      '{ROW_CFG,  REG_PACKET_ID,    8'hFF, 1'b0, 0},
      '{ROW_CFG,  REG_FRAME_LENGTH, 8'h02, 1'b0, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'hFF, 1'b1, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'hFF, 1'b1, 2},
      '{ROW_BYTE, REG_PACKET_ID,    8'h5A, 1'b0, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h5A, 1'b0, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'hFF, 1'b0, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h00, 1'b0, 0},
      // lengths below two behave as two
      '{ROW_CFG,  REG_FRAME_LENGTH, 8'h00, 1'b0, 0},
      '{ROW_CFG,  REG_PACKET_ID,    8'h80, 1'b0, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h80, 1'b0, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h80, 1'b1, 2},
      '{ROW_CFG,  REG_FRAME_LENGTH, 8'h01, 1'b0, 0},
      '{ROW_CFG,  REG_PACKET_ID,    8'h01, 1'b0, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h01, 1'b0, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h01, 1'b1, 2},
      '{ROW_CFG,  REG_FRAME_LENGTH, 8'h03, 1'b0, 0},
      '{ROW_CFG,  REG_PACKET_ID,    8'h7E, 1'b0, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h7E, 1'b0, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h12, 1'b0, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h6C, 1'b0, 0},
      '{ROW_BYTE, REG_PACKET_ID,    8'h55, 1'b0, 0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].kind == ROW_CFG) begin
        write_reg(plan[r].idx, plan[r].val);
      end else begin
        // typed frames here are all one repeated byte, last one flagged
        if (plan[r].pinned) begin
          for (k = 0; k < plan[r].pin_n; k++) begin
            w.data = plan[r].val;
            w.last = (k == plan[r].pin_n - 1);
            due_words = {due_words, w};
          end
        end
        push_byte(plan[r].val, !plan[r].pinned);
      end
    end

    // top bit of the length write is dropped, leaving 8
    write_reg(REG_PACKET_ID, 8'($urandom_range(255)));
    write_reg(REG_FRAME_LENGTH, 8'h88);
    send_mix(8);
    repeat (2) push_byte(8'($urandom_range(255)), 1'b1);

    // shortest frames, no idling on either side
    write_reg(REG_PACKET_ID, 8'h00);
    write_reg(REG_FRAME_LENGTH, 8'h02);
    idle_pct = 0;
    send_mix(20);
    push_byte(8'hC3, 1'b1);
    drain();
    idle_pct = 13;

    // top of the length field clamps to the full window
    write_reg(REG_FRAME_LENGTH, 8'h7F);
    write_reg(REG_PACKET_ID, 8'($urandom_range(255)));
    send_frame(1'b0);
    repeat (4) push_byte(8'($urandom_range(255)), 1'b1);
    send_frame(1'b0);
    repeat (3) push_byte(8'($urandom_range(255)), 1'b1);

    // long run of noise so the count passes the flush bound mid-frame
    write_reg(REG_FRAME_LENGTH, 8'h10);
    write_reg(REG_PACKET_ID, 8'($urandom_range(255)));
    repeat (125) begin
      b = 8'($urandom_range(255));
      if (b == pid_q) b = ~b;
      push_byte(b, 1'b1);
    end
    send_frame(1'b0);
    send_frame(1'b0);
    send_mix(4);

    in_push <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d bytes in and %0d frames out, lengths 2 to 64, %0d flushes",
             bytes_sent, frames_seen, flushes);
    $display("errors counted: %0d", err_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[xor_checked_frame_sync.f]
rtl/fsync_pkg.sv
rtl/fsync_fifo.sv
rtl/fsync_front.sv
rtl/xor_checked_frame_sync.sv
dv/tb_top.sv
